FILE: rtl/core/wasm_block_offset_resolver_defines.svh
// Assertion macros for the function-body framer.
// Included by the top level; depends on nothing else.
`ifndef WASM_BLOCK_OFFSET_RESOLVER_DEFINES_SVH
`define WASM_BLOCK_OFFSET_RESOLVER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define WBOR_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition at one edge that implies another at the next edge.
`define WBOR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/wbor_pkg.sv
// Shared types and constants of the function-body framer.
// Used by the record queue and the top level; depends on nothing.
package wbor_pkg;

    // Input beat: one byte of the function body.
    typedef struct packed {
        logic [7:0] code_byte;
        logic       body_start;
    } t_in_beat;

    // Output beat: one instruction or patch record.
    typedef struct packed {
        logic [1:0]  record_kind;
        logic [15:0] instr_index;
        logic [7:0]  op_value;
        logic [63:0] immediate;
        logic [15:0] patch_index;
        logic [16:0] patch_value;
        logic        function_end;
        logic        error_flag;
        logic        last;
    } t_out_beat;

    // Parse phase of the byte framer.
    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_LEB32,
        PH_LEB64,
        PH_F32,
        PH_BLOCKTYPE
    } t_phase;

    // Record kinds.
    localparam logic [1:0] KIND_INSTR      = 2'd0;
    localparam logic [1:0] KIND_ELSE_PATCH = 2'd1;
    localparam logic [1:0] KIND_END_PATCH  = 2'd2;

    // Opcodes that the framer treats specially.
    localparam logic [7:0] OP_IF   = 8'h04;
    localparam logic [7:0] OP_ELSE = 8'h05;
    localparam logic [7:0] OP_END  = 8'h0B;
    localparam logic [7:0] OP_I32  = 8'h41;
    localparam logic [7:0] OP_I64  = 8'h42;
    localparam logic [7:0] OP_F32  = 8'h43;

    // LEB128 group layout and shift limits.
    localparam int         CONT_BIT       = 7;
    localparam logic [7:0] DATA_MASK      = 8'h7F;
    localparam logic [6:0] LEB_SHIFT_STEP = 7'd7;
    localparam logic [6:0] LEB_SHIFT_MAX  = 7'd70;
    localparam logic [6:0] LEB_SHIFT_LIM  = 7'd64;

    // Raw f32 payload length in bytes.
    localparam logic [2:0] F32_BYTES = 3'd4;

    // Depth of the output record queue (power of two, at least 2).
    localparam int OUT_FIFO_DEPTH = 4;

endpackage

FILE: rtl/core/wbor_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing; holds the open-block stack.
module wbor_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/core/wbor_rec_fifo.sv
// Small record queue: takes zero, one or two records a cycle, gives one unless stalled.
// Depends on wbor_pkg for the record type and the queue depth.
module wbor_rec_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_cnt,
    input  wbor_pkg::t_out_beat i_rec0,
    input  wbor_pkg::t_out_beat i_rec1,
    output logic                o_room2,
    output logic                o_valid,
    output wbor_pkg::t_out_beat o_data,
    input  logic                i_stall
);
    import wbor_pkg::*;

    localparam int PW = $clog2(OUT_FIFO_DEPTH);
    localparam int CW = $clog2(OUT_FIFO_DEPTH + 1);

    t_out_beat       r_mem [OUT_FIFO_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   wr_ptr_1;
    logic            pop;

    assign wr_ptr_1 = r_wr_ptr + PW'(1);
    assign pop      = o_valid && !i_stall;
    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign o_room2  = (r_count <= CW'(OUT_FIFO_DEPTH - 2));

    // Record storage: first record at the write pointer, second just after it.
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_rec0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr_1] <= i_rec1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PW'(i_push_cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push_cnt) - CW'(pop);
        end
    end

endmodule

FILE: rtl/core/wasm_block_offset_resolver.sv
// WebAssembly function-body framer with if/else/end offset resolution.
//
// Input channel (i_valid / o_stall / i_data): one body byte per beat, with
// body_start marking the first byte of a new body (index and stack cleared).
// Output channel (o_valid / i_stall / o_data): instruction records, and for
// an else or end that closes an open block a following patch record.
// A byte that completes an instruction writes its records into the queue at
// the edge that accepts it; bytes inside an immediate produce nothing.
// Throughput: one byte per cycle while the queue has room. The parse state
// and stack top sit in registers, and the open-block stack sits in a
// one-port-write, one-port-read RAM whose read port always prefetches the
// entry below the top, so a pop finds its new top ready. Output bandwidth is
// one record per cycle while the receiver does not stall, so an else or end
// with a patch gives its two records in turn. Records pass through a
// four-entry queue; a byte is taken only while the queue has room for two
// records, so a stalled receiver backs up into o_stall with no record lost.
// Reset (i_rst_n low, synchronous) empties the queue, clears index, stack
// pointer and parse phase. Stack contents need no clearing.
`include "wasm_block_offset_resolver_defines.svh"

module wasm_block_offset_resolver #(
    parameter int STACK_DEPTH = 16,
    parameter int INDEX_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  wbor_pkg::t_in_beat  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output wbor_pkg::t_out_beat o_data
);
    import wbor_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int IW  = INDEX_BITS + 1;
    localparam int DW  = (IW > 17) ? IW : 17;

    // Parse state.
    t_phase          r_phase, n_phase;
    logic [63:0]     r_acc, n_acc;
    logic [6:0]      r_shift, n_shift;
    logic [2:0]      r_br, n_br;
    logic [7:0]      r_pending, n_pending;
    logic [IW-1:0]   r_next_index, n_next_index;
    logic [SPW-1:0]  r_sp, n_sp;
    logic [INDEX_BITS-1:0] r_tos, n_tos;

    // Stack RAM ports.
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [INDEX_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [INDEX_BITS-1:0] ram_rdata;
    logic [SPW-1:0]        raddr_full;

    // Byte and state after a body start is applied.
    logic                  in_acc;
    logic [7:0]            b;
    logic                  bs;
    t_phase                e_phase;
    logic [63:0]           e_acc;
    logic [6:0]            e_shift;
    logic [2:0]            e_br;
    logic [IW-1:0]         e_idx;
    logic [SPW-1:0]        e_sp;

    // Immediate assembly.
    logic [63:0]           leb_acc;
    logic [6:0]            shift_inc;
    logic [2:0]            f32_eff;
    logic [2:0]            f32_dec;
    logic [1:0]            f32_lane;
    logic [63:0]           f32_acc;

    // Completion of an instruction.
    logic                  fin;
    logic [7:0]            fin_op;
    logic [63:0]           fin_imm;
    logic [DW-1:0]         j_w;
    logic [DW-1:0]         p_w;
    logic [DW-1:0]         else_val;
    logic [DW-1:0]         end_val;
    logic                  ovf;

    // Records toward the queue.
    t_out_beat             rec0, rec1;
    logic [1:0]            push_cnt;
    logic                  room2;

    assign in_acc = i_valid && !o_stall;
    assign o_stall = !room2;
    assign b  = i_data.code_byte;
    assign bs = i_data.body_start;

    assign e_phase = bs ? PH_OPCODE : r_phase;
    assign e_acc   = bs ? 64'd0 : r_acc;
    assign e_shift = bs ? 7'd0 : r_shift;
    assign e_br    = bs ? 3'd0 : r_br;
    assign e_idx   = bs ? '0 : r_next_index;
    assign e_sp    = bs ? '0 : r_sp;

    // LEB128 group merge; groups past bit 63 are dropped.
    assign leb_acc = (e_shift < LEB_SHIFT_LIM)
                   ? (e_acc | (64'(b & DATA_MASK) << e_shift[5:0])) : e_acc;
    assign shift_inc = e_shift + LEB_SHIFT_STEP;

    // Raw f32 bytes arrive little-endian.
    assign f32_eff  = ((e_br == 3'd0) || (e_br > F32_BYTES)) ? F32_BYTES : e_br;
    assign f32_dec  = f32_eff - 3'd1;
    assign f32_lane = 2'(F32_BYTES - f32_eff);
    assign f32_acc  = e_acc | (64'(b) << {f32_lane, 3'b000});

    // Next parse phase.
    always_comb begin
        n_phase = r_phase;
        if (in_acc) begin
            unique case (e_phase) inside
                PH_LEB32, PH_LEB64: begin
                    if (!b[CONT_BIT]) begin
                        n_phase = PH_OPCODE;
                    end else begin
                        n_phase = e_phase;
                    end
                end
                PH_F32: begin
                    n_phase = (f32_dec == 3'd0) ? PH_OPCODE : PH_F32;
                end
                PH_BLOCKTYPE: begin
                    n_phase = PH_OPCODE;
                end
                PH_OPCODE: begin
                    unique case (b)
                        OP_I32:  n_phase = PH_LEB32;
                        OP_I64:  n_phase = PH_LEB64;
                        OP_F32:  n_phase = PH_F32;
                        OP_IF:   n_phase = PH_BLOCKTYPE;
                        default: n_phase = PH_OPCODE;
                    endcase
                end
                default: n_phase = PH_OPCODE;
            endcase
        end
    end

    // Immediate accumulation and instruction completion.
    always_comb begin
        n_acc     = r_acc;
        n_shift   = r_shift;
        n_br      = r_br;
        n_pending = r_pending;
        fin       = 1'b0;
        fin_op    = b;
        fin_imm   = 64'd0;
        if (in_acc) begin
            n_acc   = e_acc;
            n_shift = e_shift;
            n_br    = e_br;
            unique case (e_phase) inside
                PH_LEB32, PH_LEB64: begin
                    n_acc = leb_acc;
                    if (!b[CONT_BIT]) begin
                        fin    = 1'b1;
                        fin_op = r_pending;
                        if (e_phase == PH_LEB32) begin
                            fin_imm = {32'd0, leb_acc[31:0]};
                        end else begin
                            fin_imm = leb_acc;
                        end
                    end else begin
                        n_shift = (shift_inc > LEB_SHIFT_MAX) ? LEB_SHIFT_MAX : shift_inc;
                    end
                end
                PH_F32: begin
                    n_acc = f32_acc;
                    n_br  = f32_dec;
                    if (f32_dec == 3'd0) begin
                        fin     = 1'b1;
                        fin_op  = OP_F32;
                        fin_imm = f32_acc;
                    end
                end
                PH_BLOCKTYPE: begin
                    fin    = 1'b1;
                    fin_op = OP_IF;
                end
                PH_OPCODE: begin
                    n_pending = b;
                    n_acc     = 64'd0;
                    n_shift   = 7'd0;
                    case (b) inside
                        OP_F32: n_br = F32_BYTES;
                        OP_I32, OP_I64, OP_IF: n_br = e_br;
                        default: fin = 1'b1;
                    endcase
                end
                default: fin = 1'b0;
            endcase
        end
    end

    // Offsets from the instruction index and the open block on top.
    assign j_w      = DW'(e_idx);
    assign p_w      = DW'(r_tos);
    assign else_val = j_w - p_w + DW'(1);
    assign end_val  = j_w - p_w;
    assign ovf      = e_idx[INDEX_BITS];

    // Stack update, index advance and record build.
    always_comb begin
        n_next_index = r_next_index;
        n_sp         = r_sp;
        n_tos        = r_tos;
        ram_we       = 1'b0;
        ram_waddr    = e_sp[AW-1:0];
        ram_wdata    = e_idx[INDEX_BITS-1:0];
        push_cnt     = 2'd0;

        rec0.record_kind  = KIND_INSTR;
        rec0.instr_index  = j_w[15:0];
        rec0.op_value     = fin_op;
        rec0.immediate    = fin_imm;
        rec0.patch_index  = 16'd0;
        rec0.patch_value  = 17'd0;
        rec0.function_end = 1'b0;
        rec0.error_flag   = 1'b0;
        rec0.last         = 1'b1;

        rec1.record_kind  = KIND_ELSE_PATCH;
        rec1.instr_index  = j_w[15:0];
        rec1.op_value     = fin_op;
        rec1.immediate    = 64'd0;
        rec1.patch_index  = p_w[15:0];
        rec1.patch_value  = else_val[16:0];
        rec1.function_end = 1'b0;
        rec1.error_flag   = 1'b0;
        rec1.last         = 1'b1;

        if (in_acc) begin
            n_next_index = e_idx;
            n_sp         = e_sp;
        end
        if (in_acc && fin) begin
            push_cnt = 2'd1;
            if (ovf) begin
                // Index space exhausted: flagged record, no stack effect.
                rec0.error_flag = 1'b1;
            end else begin
                n_next_index = e_idx + IW'(1);
                case (fin_op)
                    OP_IF: begin
                        if (e_sp < SPW'(STACK_DEPTH)) begin
                            ram_we = 1'b1;
                            n_sp   = e_sp + SPW'(1);
                            n_tos  = e_idx[INDEX_BITS-1:0];
                        end else begin
                            rec0.error_flag = 1'b1;
                        end
                    end
                    OP_ELSE: begin
                        if (e_sp == '0) begin
                            rec0.error_flag = 1'b1;
                        end else begin
                            // Replace the open if with this else.
                            rec0.last = 1'b0;
                            push_cnt  = 2'd2;
                            ram_we    = 1'b1;
                            ram_waddr = AW'(e_sp - SPW'(1));
                            n_tos     = e_idx[INDEX_BITS-1:0];
                        end
                    end
                    OP_END: begin
                        if (e_sp == '0) begin
                            rec0.function_end = 1'b1;
                        end else begin
                            // Pop; the prefetched entry below becomes the top.
                            rec0.last        = 1'b0;
                            push_cnt         = 2'd2;
                            rec1.record_kind = KIND_END_PATCH;
                            rec1.patch_value = end_val[16:0];
                            n_sp             = e_sp - SPW'(1);
                            n_tos            = ram_rdata;
                        end
                    end
                    default: push_cnt = 2'd1;
                endcase
            end
        end
    end

    // Always prefetch the entry just below the next top of stack.
    assign raddr_full = n_sp - SPW'(2);
    assign ram_raddr  = raddr_full[AW-1:0];

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_OPCODE;
            r_acc        <= 64'd0;
            r_shift      <= 7'd0;
            r_br         <= 3'd0;
            r_next_index <= '0;
            r_sp         <= '0;
        end else begin
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_shift      <= n_shift;
            r_br         <= n_br;
            r_next_index <= n_next_index;
            r_sp         <= n_sp;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pending <= n_pending;
        r_tos     <= n_tos;
    end

    wbor_ram #(
        .WIDTH (INDEX_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    wbor_rec_fifo u_rec_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_rec0     (rec0),
        .i_rec1     (rec1),
        .o_room2    (room2),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

    // Checks on stack and index bookkeeping.
    `WBOR_ASSERT_ALWAYS(a_sp_bound, i_clk, i_rst_n, r_sp <= SPW'(STACK_DEPTH), "stack pointer past depth")
    `WBOR_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !in_acc, $stable(r_sp) && $stable(r_next_index) && $stable(r_phase), "state moved without a beat")
    `WBOR_ASSERT_NEXT(a_pair_out, i_clk, i_rst_n, in_acc && (push_cnt == 2'd2), o_valid, "patch pair not queued")
    `WBOR_ASSERT_NEXT(a_sp_step, i_clk, i_rst_n, in_acc && !i_data.body_start, (r_sp == $past(r_sp)) || (r_sp == $past(r_sp) + SPW'(1)) || (r_sp + SPW'(1) == $past(r_sp)), "stack pointer jumped")

endmodule

FILE: bench/wasm_block_offset_resolver_tb.sv
// Self-checking testbench for the function-body framer wasm_block_offset_resolver.
// Depends on wbor_pkg for the beat types, opcodes and record kinds, and on the RTL alone.
// A directed table runs first, then random bodies and noise under random stalls.
module wasm_block_offset_resolver_tb;
    import wbor_pkg::*;

    localparam int STACK_DEPTH   = 16;
    localparam int INDEX_BITS    = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int IDLE_PCT      = 34;
    localparam int HOLD_CYCLES   = 150;
    localparam int RANDOM_BYTES  = 1550;
    localparam int SETTLE_CYCLES = 20;
    localparam int PREDICTED     = -1;
    localparam int DIR_ROWS      = 25;

    // One row of the directed table. A typed count of PREDICTED defers to the predictor.
    typedef struct {
        t_in_beat  beat;
        int        typed_count;
        t_out_beat rec;
    } t_dir_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_beat  i_data  = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_beat o_data;

    // Predictor state of the framer.
    t_phase      fr_phase = PH_OPCODE;
    logic [63:0] fr_acc   = '0;
    logic [6:0]  fr_shift = '0;
    logic [2:0]  fr_left  = '0;
    logic [7:0]  fr_op    = '0;
    logic [16:0] fr_next  = '0;
    logic [15:0] fr_stack [STACK_DEPTH];
    logic [4:0]  fr_sp    = '0;

    // Records still awaited from the block, oldest first.
    t_out_beat awaited_records [$];

    t_dir_row dir_rows [DIR_ROWS];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       bytes_sent     = 0;
    bit       calm           = 1'b0;
    bit       body_open      = 1'b0;
    int       hold_requests  = 0;
    int       holds_served   = 0;
    int       hold_left      = 0;
    t_out_beat seen_want;

    wasm_block_offset_resolver #(
        .STACK_DEPTH(STACK_DEPTH),
        .INDEX_BITS (INDEX_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always #5 i_clk = ~i_clk;

    // Close one instruction: index bookkeeping, stack effect and its records.
    function automatic int close_instr(input logic [7:0] op, input logic [63:0] imm,
                                       output t_out_beat ra, output t_out_beat rb);
        logic [15:0] j;
        logic [15:0] p;
        ra = '0;
        rb = '0;
        fr_phase = PH_OPCODE;
        j = fr_next[15:0];
        ra.record_kind = KIND_INSTR;
        ra.instr_index = j;
        ra.op_value    = op;
        ra.immediate   = imm;
        ra.last        = 1'b1;
        // Once the index space is used up, every instruction is an error with no stack effect.
        if (fr_next[16]) begin
            ra.error_flag = 1'b1;
            return 1;
        end
        fr_next = fr_next + 17'd1;
        if (op == OP_IF) begin
            if (fr_sp < STACK_DEPTH) begin
                fr_stack[fr_sp[3:0]] = j;
                fr_sp = fr_sp + 5'd1;
            end else begin
                ra.error_flag = 1'b1;
            end
            return 1;
        end
        if (op == OP_ELSE || op == OP_END) begin
            if (fr_sp == 0) begin
                if (op == OP_ELSE) ra.error_flag = 1'b1;
                else ra.function_end = 1'b1;
                return 1;
            end
            p = fr_stack[4'(fr_sp - 5'd1)];
            ra.last        = 1'b0;
            rb.instr_index = j;
            rb.op_value    = op;
            rb.patch_index = p;
            rb.last        = 1'b1;
            if (op == OP_ELSE) begin
                rb.record_kind = KIND_ELSE_PATCH;
                rb.patch_value = {1'b0, j} - {1'b0, p} + 17'd1;
                fr_stack[4'(fr_sp - 5'd1)] = j;
            end else begin
                rb.record_kind = KIND_END_PATCH;
                rb.patch_value = {1'b0, j} - {1'b0, p};
                fr_sp = fr_sp - 5'd1;
            end
            return 2;
        end
        return 1;
    endfunction

    // Advance the predictor by one body byte; returns how many records it causes.
    function automatic int frame_byte(input t_in_beat beat,
                                      output t_out_beat ra, output t_out_beat rb);
        logic [7:0]  b;
        logic [63:0] imm;
        b  = beat.code_byte;
        ra = '0;
        rb = '0;
        if (beat.body_start) begin
            fr_phase = PH_OPCODE;
            fr_next  = '0;
            fr_sp    = '0;
            fr_acc   = '0;
            fr_shift = '0;
            fr_left  = '0;
        end
        case (fr_phase) inside
            PH_LEB32, PH_LEB64: begin
                if (fr_shift < LEB_SHIFT_LIM) fr_acc |= {56'd0, b & DATA_MASK} << fr_shift;
                if (!b[CONT_BIT]) begin
                    imm = fr_acc;
                    if (fr_phase == PH_LEB32) imm[63:32] = '0;
                    return close_instr(fr_op, imm, ra, rb);
                end
                fr_shift = fr_shift + LEB_SHIFT_STEP;
                if (fr_shift > LEB_SHIFT_MAX) fr_shift = LEB_SHIFT_MAX;
                return 0;
            end
            PH_F32: begin
                if (fr_left > F32_BYTES || fr_left == 0) fr_left = F32_BYTES;
                fr_acc |= {56'd0, b} << (8 * (4 - int'(fr_left)));
                fr_left = fr_left - 3'd1;
                if (fr_left == 0) return close_instr(OP_F32, fr_acc, ra, rb);
                return 0;
            end
            PH_BLOCKTYPE: begin
                return close_instr(OP_IF, 64'd0, ra, rb);
            end
            default: begin
            end
        endcase
        // Opcode byte: open an immediate or close a one-byte instruction.
        fr_op    = b;
        fr_acc   = '0;
        fr_shift = '0;
        case (b)
            OP_I32: begin
                fr_phase = PH_LEB32;
                return 0;
            end
            OP_I64: begin
                fr_phase = PH_LEB64;
                return 0;
            end
            OP_F32: begin
                fr_phase = PH_F32;
                fr_left  = F32_BYTES;
                return 0;
            end
            OP_IF: begin
                fr_phase = PH_BLOCKTYPE;
                return 0;
            end
            default: begin
                return close_instr(b, 64'd0, ra, rb);
            end
        endcase
    endfunction

    function automatic t_out_beat instr_rec(input logic [15:0] idx, input logic [7:0] op,
                                            input logic [63:0] imm, input logic fend,
                                            input logic err);
        t_out_beat r;
        r = '0;
        r.record_kind  = KIND_INSTR;
        r.instr_index  = idx;
        r.op_value     = op;
        r.immediate    = imm;
        r.function_end = fend;
        r.error_flag   = err;
        r.last         = 1'b1;
        return r;
    endfunction

    function automatic t_dir_row row(input logic [7:0] code, input logic start,
                                     input int typed_count, input t_out_beat rec);
        t_dir_row r;
        r.beat.code_byte  = code;
        r.beat.body_start = start;
        r.typed_count     = typed_count;
        r.rec             = rec;
        return r;
    endfunction

    // A random one-byte opcode that the framer does not treat specially.
    function automatic logic [7:0] plain_op();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        case (v) inside
            OP_IF, OP_ELSE, OP_END, OP_I32, OP_I64, OP_F32: v = 8'h01;
            default: begin
            end
        endcase
        return v;
    endfunction

    function automatic bit field_ok(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit record_matches(input t_out_beat want, input t_out_beat got);
        bit ok;
        ok = 1'b1;
        ok &= field_ok("record_kind", 64'(want.record_kind), 64'(got.record_kind));
        ok &= field_ok("instr_index", 64'(want.instr_index), 64'(got.instr_index));
        ok &= field_ok("op_value", 64'(want.op_value), 64'(got.op_value));
        ok &= field_ok("immediate", want.immediate, got.immediate);
        ok &= field_ok("patch_index", 64'(want.patch_index), 64'(got.patch_index));
        ok &= field_ok("patch_value", 64'(want.patch_value), 64'(got.patch_value));
        ok &= field_ok("function_end", 64'(want.function_end), 64'(got.function_end));
        ok &= field_ok("error_flag", 64'(want.error_flag), 64'(got.error_flag));
        ok &= field_ok("last", 64'(want.last), 64'(got.last));
        return ok;
    endfunction

    // Offer one beat, idling at random beforehand, and return at the edge that takes it.
    task automatic offer_beat(input t_in_beat beat);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic queue_prediction(input t_in_beat beat);
        int        n;
        t_out_beat ra;
        t_out_beat rb;
        n = frame_byte(beat, ra, rb);
        if (n > 0) awaited_records.push_back(ra);
        if (n > 1) awaited_records.push_back(rb);
    endtask

    task automatic drive_byte(input logic [7:0] b, input logic s);
        t_in_beat beat;
        beat.code_byte  = b;
        beat.body_start = s;
        offer_beat(beat);
        queue_prediction(beat);
        bytes_sent++;
    endtask

    // The first byte of a random body carries body_start.
    task automatic put_byte(input logic [7:0] b);
        drive_byte(b, body_open);
        body_open = 1'b0;
    endtask

    // A constant with an LEB128 immediate, now and then longer than its width.
    task automatic send_leb(input logic [7:0] op, input int short_max, input int long_max);
        int         len;
        bit         all_ones;
        logic [7:0] v;
        len = ($urandom_range(4) == 0) ? $urandom_range(long_max, short_max + 1)
                                       : $urandom_range(short_max, 1);
        all_ones = ($urandom_range(3) == 0);
        put_byte(op);
        for (int k = 0; k < len; k++) begin
            v = all_ones ? DATA_MASK : 8'($urandom_range(127));
            if (k < len - 1) v[CONT_BIT] = 1'b1;
            put_byte(v);
        end
    endtask

    // A mostly well-formed body with random content and nesting, closed by its ends.
    task automatic send_body();
        int n_instr;
        int depth;
        int pick;
        int n;
        body_open = 1'b1;
        depth     = 0;
        n_instr   = $urandom_range(30, 1);
        for (int k = 0; k < n_instr; k++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                put_byte(plain_op());
            end else if (pick < 52) begin
                send_leb(OP_I32, 5, 11);
            end else if (pick < 60) begin
                send_leb(OP_I64, 10, 13);
            end else if (pick < 66) begin
                put_byte(OP_F32);
                repeat (4) put_byte(8'($urandom_range(255)));
            end else if (pick < 80) begin
                // Now and then nest deeper than the stack holds.
                n = ($urandom_range(14) == 0) ? $urandom_range(20, 17) : 1;
                repeat (n) begin
                    put_byte(OP_IF);
                    put_byte(8'($urandom_range(255)));
                end
                depth += n;
            end else if (pick < 88) begin
                if (depth > 0 || $urandom_range(9) == 0) put_byte(OP_ELSE);
            end else begin
                put_byte(OP_END);
                if (depth == 0) return;
                depth--;
            end
        end
        repeat (depth + 1) put_byte(OP_END);
    endtask

    // Random bytes with random body starts, which also cut immediates short.
    task automatic send_noise();
        int n;
        n = $urandom_range(8, 1);
        repeat (n) drive_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
    endtask

    // Receiver: random stalls, a long hold on request, and calm stretches.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Every record beat taken is checked against the oldest awaited record.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_records.size() == 0) begin
                $error("unexpected record: kind %0d index %0d op 0x%02h",
                       o_data.record_kind, o_data.instr_index, o_data.op_value);
                mismatch_count++;
            end else begin
                seen_want = awaited_records.pop_front();
                if (!record_matches(seen_want, o_data)) mismatch_count++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        bit        hold_asked;
        t_out_beat ra;
        t_out_beat rb;
        hold_asked = 1'b0;

        // Directed table: empty-stack end and else, opcode extremes, widest i32,
        // f32 raw bits, if/else/end patches, bytes after the closing end, and a
        // body start that drops a pending i64.
        dir_rows[0]  = row(OP_END, 1'b1, 1, instr_rec(16'd0, OP_END, 64'd0, 1'b1, 1'b0));
        dir_rows[1]  = row(OP_ELSE, 1'b0, 1, instr_rec(16'd1, OP_ELSE, 64'd0, 1'b0, 1'b1));
        dir_rows[2]  = row(8'h00, 1'b0, 1, instr_rec(16'd2, 8'h00, 64'd0, 1'b0, 1'b0));
        dir_rows[3]  = row(8'hFF, 1'b0, 1, instr_rec(16'd3, 8'hFF, 64'd0, 1'b0, 1'b0));
        dir_rows[4]  = row(OP_I32, 1'b0, 0, '0);
        dir_rows[5]  = row(8'hFF, 1'b0, 0, '0);
        dir_rows[6]  = row(8'hFF, 1'b0, 0, '0);
        dir_rows[7]  = row(8'hFF, 1'b0, 0, '0);
        dir_rows[8]  = row(8'hFF, 1'b0, 0, '0);
        dir_rows[9]  = row(8'h7F, 1'b0, 1,
                           instr_rec(16'd4, OP_I32, 64'hFFFF_FFFF, 1'b0, 1'b0));
        dir_rows[10] = row(OP_F32, 1'b0, 0, '0);
        dir_rows[11] = row(8'h00, 1'b0, 0, '0);
        dir_rows[12] = row(8'h00, 1'b0, 0, '0);
        dir_rows[13] = row(8'h80, 1'b0, 0, '0);
        dir_rows[14] = row(8'hFF, 1'b0, 1,
                           instr_rec(16'd5, OP_F32, 64'hFF80_0000, 1'b0, 1'b0));
        dir_rows[15] = row(OP_IF, 1'b0, 0, '0);
        dir_rows[16] = row(8'h40, 1'b0, 1, instr_rec(16'd6, OP_IF, 64'd0, 1'b0, 1'b0));
        dir_rows[17] = row(OP_ELSE, 1'b0, PREDICTED, '0);
        dir_rows[18] = row(OP_END, 1'b0, PREDICTED, '0);
        dir_rows[19] = row(OP_END, 1'b0, 1, instr_rec(16'd9, OP_END, 64'd0, 1'b1, 1'b0));
        dir_rows[20] = row(OP_I64, 1'b0, 0, '0);
        dir_rows[21] = row(8'h81, 1'b0, 0, '0);
        dir_rows[22] = row(OP_END, 1'b1, 1, instr_rec(16'd0, OP_END, 64'd0, 1'b1, 1'b0));
        dir_rows[23] = row(OP_IF, 1'b1, 0, '0);
        dir_rows[24] = row(8'h7F, 1'b0, 1, instr_rec(16'd0, OP_IF, 64'd0, 1'b0, 1'b0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++) begin
            offer_beat(dir_rows[k].beat);
            if (dir_rows[k].typed_count == PREDICTED) begin
                queue_prediction(dir_rows[k].beat);
            end else begin
                void'(frame_byte(dir_rows[k].beat, ra, rb));
                if (dir_rows[k].typed_count > 0) awaited_records.push_back(dir_rows[k].rec);
            end
        end

        // Random part: mostly well-formed bodies, with a long receiver hold early
        // on and a stretch with no idling on either side.
        while (bytes_sent < RANDOM_BYTES) begin
            calm = (bytes_sent >= 700 && bytes_sent < 1000);
            if (!hold_asked && bytes_sent >= 300) begin
                hold_asked = 1'b1;
                hold_requests++;
            end
            if ($urandom_range(99) < 85) send_body();
            else send_noise();
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        // Drain, then give late or stray records a chance to show up.
        while (awaited_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && awaited_records.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/wbor_pkg.sv
rtl/core/wbor_ram.sv
rtl/core/wbor_rec_fifo.sv
rtl/core/wasm_block_offset_resolver.sv
bench/wasm_block_offset_resolver_tb.sv
